[rtl/core/cmfuv_pkg.sv]
`default_nettype none
package cmfuv_pkg;

   localparam int CompBits  = 16;
   localparam int CoordBits = 16;
   localparam int DenBits   = CompBits + 1;
   localparam int NumBits   = DenBits + CoordBits;
   localparam int ExtBits   = CompBits + 2;
   localparam int Latency   = CoordBits + 1;

   typedef enum logic [2:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   typedef enum logic [1:0] {
      MODE_DIV  = 2'd0,
      MODE_ZERO = 2'd1,
      MODE_FULL = 2'd2,
      MODE_HALF = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [DenBits-1:0]     rem;
      logic [CoordBits-1:0]   low;
      logic [DenBits-1:0]     den;
      logic [CoordBits-1:0]   quo;
   } lane_type;

   typedef struct packed {
      logic     vld;
      face_type face;
      lane_type u;
      lane_type v;
   } word_type;

endpackage
`default_nettype wire

[rtl/core/cmfuv_front.sv]
`default_nettype none
module cmfuv_front
   import cmfuv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire logic [CompBits-1:0] dir_x,
   input  wire logic [CompBits-1:0] dir_y,
   input  wire logic [CompBits-1:0] dir_z,
   output word_type                 word_out
);

   word_type word_ff, word_in;

   function automatic lane_type setup_lane(input logic signed [ExtBits-1:0] n,
                                           input logic signed [ExtBits-1:0] m,
                                           input logic flip);
      lane_type                    l;
      logic signed [ExtBits-1:0]   nn;
      logic signed [ExtBits-1:0]   t;
      logic signed [ExtBits-1:0]   m2;
      logic [DenBits-1:0]          t17;
      logic [NumBits-1:0]          num;
      nn  = flip ? -n : n;
      t   = nn + m;
      m2  = m <<< 1;
      t17 = t[DenBits-1:0];
      num = {t17, {CoordBits{1'b0}}} - {{CoordBits{1'b0}}, t17};
      l.rem = num[NumBits-1:CoordBits];
      l.low = num[CoordBits-1:0];
      l.den = m2[DenBits-1:0];
      l.quo = '0;
      if (m == '0) begin
         if (nn > 0)      l.mode = MODE_FULL;
         else if (nn < 0) l.mode = MODE_ZERO;
         else             l.mode = MODE_HALF;
      end else if (t <= 0) begin
         l.mode = MODE_ZERO;
      end else if (t >= m2) begin
         l.mode = MODE_FULL;
      end else begin
         l.mode = MODE_DIV;
      end
      return l;
   endfunction

   logic signed [ExtBits-1:0] x, y, z, ax, ay, az;

   always_comb begin
      x  = signed'({{2{dir_x[CompBits-1]}}, dir_x});
      y  = signed'({{2{dir_y[CompBits-1]}}, dir_y});
      z  = signed'({{2{dir_z[CompBits-1]}}, dir_z});
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      word_in.vld = take;
      if (ax > ay && ax > az) begin
         word_in.face = (x > 0) ? FACE_POS_X : FACE_NEG_X;
         word_in.u    = setup_lane(z, ax, !(x > 0));
         word_in.v    = setup_lane(y, ax, 1'b0);
      end else if (ay > ax && ay > az) begin
         word_in.face = (y > 0) ? FACE_POS_Y : FACE_NEG_Y;
         word_in.u    = setup_lane(x, ay, 1'b0);
         word_in.v    = setup_lane(z, ay, !(y > 0));
      end else begin
         word_in.face = (z > 0) ? FACE_POS_Z : FACE_NEG_Z;
         word_in.u    = setup_lane(x, az, z > 0);
         word_in.v    = setup_lane(y, az, 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) word_ff.vld <= 1'b0;
   end

   assign word_out = word_ff;

endmodule
`default_nettype wire

[rtl/core/cmfuv_div_cell.sv]
`default_nettype none
module cmfuv_div_cell
   import cmfuv_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  word_type  word_in_p,
   output word_type  word_out
);

   word_type word_ff, word_in;

   function automatic lane_type step(input lane_type l);
      lane_type           r;
      logic [DenBits:0]   r2;
      logic               b;
      r  = l;
      r2 = {l.rem, l.low[CoordBits-1]};
      b  = (r2 >= {1'b0, l.den});
      r2 = b ? r2 - {1'b0, l.den} : r2;
      r.rem = r2[DenBits-1:0];
      r.low = {l.low[CoordBits-2:0], 1'b0};
      r.quo = {l.quo[CoordBits-2:0], b};
      return r;
   endfunction

   always_comb begin
      word_in   = word_in_p;
      word_in.u = step(word_in_p.u);
      word_in.v = step(word_in_p.v);
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) word_ff.vld <= 1'b0;
   end

   assign word_out = word_ff;

endmodule
`default_nettype wire

[rtl/core/cube_map_face_uv_select.sv]
`default_nettype none
// Cube map face select: takes one direction per cycle (busy is always low) and
// returns its face and u/v coordinates, registered in the setup stage and then in
// each divider cell, on a one-cycle rsp_valid strobe. The divider chain has one cell
// per quotient bit after one setup stage; the receiver cannot stall the block.
module cube_map_face_uv_select
   import cmfuv_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [CompBits-1:0]  req_dir_x,
   input  wire logic [CompBits-1:0]  req_dir_y,
   input  wire logic [CompBits-1:0]  req_dir_z,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_face,
   output logic [CoordBits-1:0]      rsp_coord_u,
   output logic [CoordBits-1:0]      rsp_coord_v
);

   word_type chain [CoordBits+1];

   cmfuv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (start),
      .dir_x    (req_dir_x),
      .dir_y    (req_dir_y),
      .dir_z    (req_dir_z),
      .word_out (chain[0])
   );

   for (genvar i = 0; i < CoordBits; i++) begin : g_cell
      cmfuv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .word_in_p (chain[i]),
         .word_out  (chain[i+1])
      );
   end

   function automatic logic [CoordBits-1:0] finish(input lane_type l);
      logic [CoordBits-1:0] c;
      case (l.mode)
         MODE_DIV:  c = l.quo;
         MODE_ZERO: c = '0;
         MODE_FULL: c = '1;
         default:   c = {1'b0, {(CoordBits-1){1'b1}}};
      endcase
      return c;
   endfunction

   assign busy        = 1'b0;
   assign rsp_valid   = chain[CoordBits].vld;
   assign rsp_face    = chain[CoordBits].face;
   assign rsp_coord_u = finish(chain[CoordBits].u);
   assign rsp_coord_v = finish(chain[CoordBits].v);

`ifndef SYNTHESIS
   a_face_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_face <= FACE_NEG_Z))
      else $error("face out of range");
   a_strobe_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, Latency))
      else $error("result without a request");
   a_z_face : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start && req_dir_x == '0 && req_dir_y == '0, Latency))
      |-> (rsp_face == FACE_POS_Z || rsp_face == FACE_NEG_Z))
      else $error("Z face expected");
`endif

endmodule
`default_nettype wire
